/* hdl/lat_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the live allocation tracker.
// Depends on nothing; every other file refers to it by scoped names.
package lat_pkg;

  localparam int TABLE_SLOTS_DEF  = 4096;
  localparam int SITE_ENTRIES_DEF = 4096;

  localparam logic [63:0] MIX_C0 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  localparam logic [63:0] KEY_EMPTY = 64'd0;
  localparam logic [63:0] KEY_TOMB  = 64'd1;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_FRAME   = 2'd2;
  localparam logic [1:0] MODE_STARTUP = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_REUSED    = 3'd1;
  localparam logic [2:0] ST_FREED     = 3'd2;
  localparam logic [2:0] ST_UNTRACKED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_FRAME     = 3'd5;
  localparam logic [2:0] ST_STARTUP   = 3'd6;
  localparam logic [2:0] ST_IGNORED   = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] address;
    logic [31:0] size_bytes;
    logic [11:0] site;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] bytes_in_use;
    logic [12:0] blocks_in_use;
    logic [63:0] bytes_in_use_max;
    logic [63:0] total_allocations;
    logic [63:0] untracked_frees;
    logic [63:0] site_bytes_in_use;
    logic [63:0] site_peak_bytes;
    logic [63:0] window_count;
    logic [63:0] window_bytes;
    logic [63:0] peak_frame_count;
    logic [63:0] peak_frame_number;
  } result_t;

endpackage

/* hdl/live_allocation_tracker.sv */
`timescale 1ns / 1ps
// Live allocation tracker: hashed slot memory, per-site memory and totals; needs lat_pkg.
// Frame, startup and ignored transactions strobe done in the cycle after acceptance.
// Allocate and free hash the address, reduce the hash modulo TABLE_SLOTS and then probe
// slots one per cycle from the home slot before done strobes.
// busy stays high through the strobe; the next transaction is taken in the cycle after it.
// After reset a clearing pass holds busy while it empties every slot and site entry.
module live_allocation_tracker #(
  parameter int TABLE_SLOTS  = lat_pkg::TABLE_SLOTS_DEF,
  parameter int SITE_ENTRIES = lat_pkg::SITE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lat_pkg::cmd_t    cmd,
  output logic             done,
  output lat_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);

  localparam int IW    = $clog2(TABLE_SLOTS);
  localparam int SIW   = (SITE_ENTRIES > 1) ? $clog2(SITE_ENTRIES) : 1;
  localparam int CLR_N = (TABLE_SLOTS > SITE_ENTRIES) ? TABLE_SLOTS : SITE_ENTRIES;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [IW+2:0] FULL_LIM = (IW+3)'(3 * TABLE_SLOTS);
  localparam logic [IW-1:0] T_LAST   = IW'(TABLE_SLOTS - 1);
  localparam logic [31:0]   T32      = 32'(TABLE_SLOTS);
  localparam logic [32:0]   RECIP    =
    33'(((64'd1 << (32 + IW)) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] size;
    logic [11:0] site;
  } slot_t;

  typedef struct packed {
    logic [63:0] live;
    logic [63:0] peak;
  } site_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_MOD, S_PROBE0, S_PROBE, S_DECIDE,
    S_SRD1, S_SWR1, S_SRD2, S_SWR2, S_OUT
  } state_t;

  state_t state;

  slot_t slot_mem [TABLE_SLOTS];
  site_t site_mem [SITE_ENTRIES];
  slot_t slot_q;
  site_t site_q;

  logic          slot_we;
  logic [IW-1:0] slot_waddr;
  slot_t         slot_wdata;
  logic [IW-1:0] slot_raddr;
  logic           site_we;
  logic [SIW-1:0] site_waddr;
  site_t          site_wdata;
  logic [SIW-1:0] site_raddr;

  logic        cfg_sites;
  logic [CW-1:0] clr;

  logic [1:0]  op;
  logic [63:0] key;
  logic [31:0] size;
  logic [11:0] site_c;

  logic [63:0] mul_a;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [1:0]  mstep;
  logic        mpass;
  logic [31:0] hv;
  logic [IW-1:0] rem;
  logic        modcnt;
  logic [64:0] qprod;

  logic [IW-1:0] chk;
  logic [IW-1:0] pcnt;
  logic          found;
  logic [IW-1:0] found_idx;
  logic [31:0]   old_size;
  logic [11:0]   old_site;
  logic          tomb_seen;
  logic [IW-1:0] tomb_idx;
  logic          empty_hit;
  logic [IW-1:0] empty_idx;

  logic [IW:0] occ;
  logic [IW:0] live_n;
  logic [63:0] live_tot;
  logic [63:0] peak_tot;
  logic [63:0] lifetime;
  logic [63:0] untracked;
  logic [63:0] fac;
  logic [63:0] fbt;
  logic [63:0] frame_no;
  logic [63:0] worst_cnt;
  logic [63:0] worst_no;
  logic        startup_done;

  logic [2:0]  status;
  logic [63:0] s_live;
  logic [63:0] s_peak;
  logic [63:0] win_cnt;
  logic [63:0] win_bytes;

  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_r;
  logic [63:0] mix0;
  logic [63:0] mres;
  logic [IW-1:0] rem_next;
  logic [IW-1:0] chk_next;
  logic [IW-1:0] ins_idx;
  logic          ins_empty;
  logic          ins_none;
  logic          tbl_full;
  logic [63:0] live_rel;
  logic [63:0] live_add;
  logic [63:0] site_add;

  always_comb begin
    mix0 = cmd.address + lat_pkg::MIX_C0;
    mix0 = mix0 ^ (mix0 >> 30);
  end

  always_comb begin
    case (mstep)
      2'd1:    begin mul_x = mul_a[63:32]; mul_y = mpass ? lat_pkg::MIX_C2[31:0]
                                                         : lat_pkg::MIX_C1[31:0]; end
      2'd2:    begin mul_x = mul_a[31:0];  mul_y = mpass ? lat_pkg::MIX_C2[63:32]
                                                         : lat_pkg::MIX_C1[63:32]; end
      default: begin mul_x = mul_a[31:0];  mul_y = mpass ? lat_pkg::MIX_C2[31:0]
                                                         : lat_pkg::MIX_C1[31:0]; end
    endcase
    mul_r = mul_x * mul_y;
    mres  = acc + {prod[31:0], 32'd0};
  end

  // The home slot is hv modulo TABLE_SLOTS through a reciprocal multiplication.
  always_comb begin
    logic [31:0] quot;
    logic [31:0] diff;
    quot     = 32'(qprod >> (32 + IW));
    diff     = hv - quot * T32;
    rem_next = diff[IW-1:0];
  end

  always_comb begin
    chk_next  = (chk == T_LAST) ? '0 : chk + 1'b1;
    ins_idx   = tomb_seen ? tomb_idx : empty_idx;
    ins_empty = !tomb_seen && empty_hit;
    ins_none  = !tomb_seen && !empty_hit;
    tbl_full  = ins_none || (ins_empty && ({occ + 1'b1, 2'b00} >= FULL_LIM));
    live_rel  = found ? live_tot - 64'(old_size) : live_tot;
    live_add  = live_rel + 64'(size);
    site_add  = site_q.live + 64'(size);
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = found_idx;
    slot_wdata = '{key: key, size: size, site: site_c};
    slot_raddr = (state == S_PROBE0) ? rem : chk_next;
    site_we    = 1'b0;
    site_waddr = SIW'(old_site);
    site_wdata = '{live: site_q.live - 64'(old_size), peak: site_q.peak};
    site_raddr = (state == S_SRD1) ? SIW'(old_site) : SIW'(site_c);
    case (state)
      S_CLEAR: begin
        slot_waddr = clr[IW-1:0];
        slot_wdata = '{key: lat_pkg::KEY_EMPTY, size: 32'd0, site: 12'd0};
        slot_we    = (32'(clr) < 32'(TABLE_SLOTS));
        site_waddr = clr[SIW-1:0];
        site_wdata = '0;
        site_we    = (32'(clr) < 32'(SITE_ENTRIES));
      end
      S_DECIDE: begin
        if (op == lat_pkg::MODE_FREE) begin
          slot_we    = found;
          slot_wdata = '{key: lat_pkg::KEY_TOMB, size: 32'd0, site: 12'd0};
        end else if (found) begin
          slot_we = 1'b1;
        end else begin
          slot_we    = !tbl_full;
          slot_waddr = ins_idx;
        end
      end
      S_SWR1: begin
        site_we = 1'b1;
      end
      S_SWR2: begin
        site_we    = (status != lat_pkg::ST_FULL);
        site_waddr = SIW'(site_c);
        site_wdata = '{live: site_add,
                       peak: (site_add > site_q.peak) ? site_add : site_q.peak};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (site_we) begin
      site_mem[site_waddr] <= site_wdata;
    end
    site_q <= site_mem[site_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      cfg_sites    <= 1'b0;
      occ          <= '0;
      live_n       <= '0;
      live_tot     <= '0;
      peak_tot     <= '0;
      lifetime     <= '0;
      untracked    <= '0;
      fac          <= '0;
      fbt          <= '0;
      frame_no     <= '0;
      worst_cnt    <= '0;
      worst_no     <= '0;
      startup_done <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_sites <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == 32'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op        <= cmd.mode;
            key       <= cmd.address;
            size      <= cmd.size_bytes;
            site_c    <= (cfg_sites && (32'(cmd.site) < 32'(SITE_ENTRIES))) ? cmd.site
                                                                            : 12'd0;
            s_live    <= '0;
            s_peak    <= '0;
            win_cnt   <= fac;
            win_bytes <= fbt;
            status    <= lat_pkg::ST_IGNORED;
            mul_a     <= mix0;
            mstep     <= 2'd0;
            mpass     <= 1'b0;
            state     <= S_OUT;
            case (cmd.mode)
              lat_pkg::MODE_FRAME: begin
                frame_no <= frame_no + 1'b1;
                if (fac > worst_cnt) begin
                  worst_cnt <= fac;
                  worst_no  <= frame_no + 1'b1;
                end
                fac    <= '0;
                fbt    <= '0;
                status <= lat_pkg::ST_FRAME;
              end
              lat_pkg::MODE_STARTUP: begin
                if (!startup_done) begin
                  startup_done <= 1'b1;
                  fac          <= '0;
                  fbt          <= '0;
                  status       <= lat_pkg::ST_STARTUP;
                end
              end
              default: begin
                if (cmd.address != lat_pkg::KEY_EMPTY &&
                    cmd.address != lat_pkg::KEY_TOMB) begin
                  state <= S_MUL;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= mul_r;
          mstep <= mstep + 1'b1;
          case (mstep)
            2'd0: begin
            end
            2'd1: acc <= prod;
            2'd2: acc <= mres;
            default: begin
              if (!mpass) begin
                mul_a <= mres ^ (mres >> 27);
                mpass <= 1'b1;
              end else begin
                hv     <= mres[31:0] ^ mres[62:31];
                rem    <= '0;
                modcnt <= 1'b0;
                state  <= S_MOD;
              end
            end
          endcase
        end
        S_MOD: begin
          modcnt <= 1'b1;
          if (!modcnt) begin
            qprod <= 65'(hv) * 65'(RECIP);
          end else begin
            rem   <= rem_next;
            state <= S_PROBE0;
          end
        end
        S_PROBE0: begin
          chk       <= rem;
          pcnt      <= '0;
          found     <= 1'b0;
          tomb_seen <= 1'b0;
          empty_hit <= 1'b0;
          state     <= S_PROBE;
        end
        S_PROBE: begin
          chk  <= chk_next;
          pcnt <= pcnt + 1'b1;
          if (slot_q.key == lat_pkg::KEY_EMPTY) begin
            empty_hit <= 1'b1;
            empty_idx <= chk;
            state     <= S_DECIDE;
          end else if (slot_q.key == key) begin
            found     <= 1'b1;
            found_idx <= chk;
            old_size  <= slot_q.size;
            old_site  <= slot_q.site;
            state     <= S_DECIDE;
          end else begin
            if (slot_q.key == lat_pkg::KEY_TOMB && !tomb_seen) begin
              tomb_seen <= 1'b1;
              tomb_idx  <= chk;
            end
            if (pcnt == T_LAST) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (op == lat_pkg::MODE_FREE) begin
            if (found) begin
              live_tot <= live_rel;
              live_n   <= live_n - 1'b1;
              status   <= lat_pkg::ST_FREED;
              state    <= S_SRD1;
            end else begin
              untracked <= untracked + 1'b1;
              status    <= lat_pkg::ST_UNTRACKED;
              state     <= S_OUT;
            end
          end else if (!found && tbl_full) begin
            status <= lat_pkg::ST_FULL;
            state  <= S_SRD2;
          end else begin
            if (found) begin
              status <= lat_pkg::ST_REUSED;
              state  <= S_SRD1;
            end else begin
              status <= lat_pkg::ST_INSERTED;
              live_n <= live_n + 1'b1;
              if (ins_empty) begin
                occ <= occ + 1'b1;
              end
              state <= S_SRD2;
            end
            live_tot  <= live_add;
            if (live_add > peak_tot) begin
              peak_tot <= live_add;
            end
            lifetime  <= lifetime + 1'b1;
            fac       <= fac + 1'b1;
            fbt       <= fbt + 64'(size);
            win_cnt   <= fac + 1'b1;
            win_bytes <= fbt + 64'(size);
          end
        end
        S_SRD1: begin
          state <= S_SWR1;
        end
        S_SWR1: begin
          if (op == lat_pkg::MODE_FREE) begin
            s_live <= site_q.live - 64'(old_size);
            s_peak <= site_q.peak;
            state  <= S_OUT;
          end else begin
            state <= S_SRD2;
          end
        end
        S_SRD2: begin
          state <= S_SWR2;
        end
        S_SWR2: begin
          if (status == lat_pkg::ST_FULL) begin
            s_live <= site_q.live;
            s_peak <= site_q.peak;
          end else begin
            s_live <= site_add;
            s_peak <= (site_add > site_q.peak) ? site_add : site_q.peak;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  always_comb begin
    result.status            = status;
    result.bytes_in_use      = live_tot;
    result.blocks_in_use     = 13'(live_n);
    result.bytes_in_use_max  = peak_tot;
    result.total_allocations = lifetime;
    result.untracked_frees   = untracked;
    result.site_bytes_in_use = s_live;
    result.site_peak_bytes   = s_peak;
    result.window_count      = win_cnt;
    result.window_bytes      = win_bytes;
    result.peak_frame_count  = worst_cnt;
    result.peak_frame_number = worst_no;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy held after the result strobe");

  a_untracked_site: assert property (@(posedge clk) disable iff (rst)
    done && result.status == lat_pkg::ST_UNTRACKED |->
      result.site_bytes_in_use == 64'd0 && result.site_peak_bytes == 64'd0)
    else $error("untracked free reported site totals");

  a_alloc_peak: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == lat_pkg::ST_INSERTED ||
             result.status == lat_pkg::ST_REUSED) |->
      result.bytes_in_use_max >= result.bytes_in_use)
    else $error("live bytes above peak after allocate");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for the live allocation tracker: a queued driver, a strobe monitor
// and a behavioral table predictor checked field by field. Depends on lat_pkg.
module tb;

  localparam int SLOTS = lat_pkg::TABLE_SLOTS_DEF;
  localparam int SITES = lat_pkg::SITE_ENTRIES_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lat_pkg::cmd_t cmd = '0;
  logic done;
  lat_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  live_allocation_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state.
  logic [63:0] tbl_key [SLOTS];
  logic [31:0] tbl_size [SLOTS];
  logic [11:0] tbl_site [SLOTS];
  logic [63:0] site_live [SITES];
  logic [63:0] site_peak [SITES];
  int unsigned occupied, live_n;
  logic [63:0] live_b, peak_b, allocs, untracked;
  logic [63:0] frame_cnt, frame_b, frame_no, worst_cnt, worst_no;
  bit boot_window_shut, use_sites;

  lat_pkg::cmd_t pending_cmds[$];
  lat_pkg::result_t expected_results[$];
  logic [63:0] live_addrs[$];
  int errors = 0;
  int hold_off = 0;

  function automatic logic [63:0] splitmix(logic [63:0] v);
    v = v + lat_pkg::MIX_C0;
    v = (v ^ (v >> 30)) * lat_pkg::MIX_C1;
    v = (v ^ (v >> 27)) * lat_pkg::MIX_C2;
    return v ^ (v >> 31);
  endfunction

  function automatic int find_key(logic [63:0] a);
    int i;
    i = splitmix(a) % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_key[i] == lat_pkg::KEY_EMPTY) return SLOTS;
      if (tbl_key[i] == a) return i;
      i = (i + 1) % SLOTS;
    end
    return SLOTS;
  endfunction

  function automatic int find_open(logic [63:0] a);
    int i;
    i = splitmix(a) % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_key[i] == lat_pkg::KEY_EMPTY || tbl_key[i] == lat_pkg::KEY_TOMB) return i;
      i = (i + 1) % SLOTS;
    end
    return SLOTS;
  endfunction

  function automatic void drop_entry(int i);
    live_b = live_b - tbl_size[i];
    live_n = live_n - 1;
    site_live[tbl_site[i]] = site_live[tbl_site[i]] - tbl_size[i];
  endfunction

  function automatic lat_pkg::result_t track(lat_pkg::cmd_t c);
    lat_pkg::result_t r;
    bit has_site;
    int s, i;
    has_site = 0;
    s = 0;
    r = '0;
    r.status = lat_pkg::ST_IGNORED;
    r.window_count = frame_cnt;
    r.window_bytes = frame_b;
    if (c.mode == lat_pkg::MODE_ALLOC) begin
      if (c.address != lat_pkg::KEY_EMPTY && c.address != lat_pkg::KEY_TOMB) begin
        i = find_key(c.address);
        s = (use_sites && int'(c.site) < SITES) ? int'(c.site) : 0;
        has_site = 1;
        if (i < SLOTS) begin
          drop_entry(i);
          r.status = lat_pkg::ST_REUSED;
        end else begin
          i = find_open(c.address);
          if (i >= SLOTS ||
              (tbl_key[i] == lat_pkg::KEY_EMPTY && (occupied + 1) * 4 >= SLOTS * 3))
            r.status = lat_pkg::ST_FULL;
          else begin
            if (tbl_key[i] == lat_pkg::KEY_EMPTY) occupied++;
            tbl_key[i] = c.address;
            r.status = lat_pkg::ST_INSERTED;
          end
        end
        if (r.status != lat_pkg::ST_FULL) begin
          tbl_size[i] = c.size_bytes;
          tbl_site[i] = s[11:0];
          live_n++;
          live_b = live_b + c.size_bytes;
          if (live_b > peak_b) peak_b = live_b;
          allocs++;
          frame_cnt++;
          frame_b = frame_b + c.size_bytes;
          site_live[s] = site_live[s] + c.size_bytes;
          if (site_live[s] > site_peak[s]) site_peak[s] = site_live[s];
          r.window_count = frame_cnt;
          r.window_bytes = frame_b;
        end
      end
    end else if (c.mode == lat_pkg::MODE_FREE) begin
      if (c.address != lat_pkg::KEY_EMPTY && c.address != lat_pkg::KEY_TOMB) begin
        i = find_key(c.address);
        if (i >= SLOTS) begin
          untracked++;
          r.status = lat_pkg::ST_UNTRACKED;
        end else begin
          drop_entry(i);
          has_site = 1;
          s = tbl_site[i];
          tbl_key[i] = lat_pkg::KEY_TOMB;
          tbl_size[i] = '0;
          tbl_site[i] = '0;
          r.status = lat_pkg::ST_FREED;
        end
      end
    end else if (c.mode == lat_pkg::MODE_FRAME) begin
      frame_no++;
      if (frame_cnt > worst_cnt) begin
        worst_cnt = frame_cnt;
        worst_no = frame_no;
      end
      frame_cnt = '0;
      frame_b = '0;
      r.status = lat_pkg::ST_FRAME;
    end else if (!boot_window_shut) begin
      boot_window_shut = 1;
      frame_cnt = '0;
      frame_b = '0;
      r.status = lat_pkg::ST_STARTUP;
    end
    r.bytes_in_use = live_b;
    r.blocks_in_use = live_n[12:0];
    r.bytes_in_use_max = peak_b;
    r.total_allocations = allocs;
    r.untracked_frees = untracked;
    r.site_bytes_in_use = has_site ? site_live[s] : '0;
    r.site_peak_bytes = has_site ? site_peak[s] : '0;
    r.peak_frame_count = worst_cnt;
    r.peak_frame_number = worst_no;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: inputs change on the falling edge; start is raised only while idle.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      hold_off <= 0;
    end else if (start && busy) begin
      start <= 1'b0;
      hold_off <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 5));
    end else if (!start && hold_off > 0) begin
      hold_off <= hold_off - 1;
    end else if (!start && !busy && pending_cmds.size() > 0) begin
      cmd <= pending_cmds[0];
      start <= 1'b1;
    end
  end

  // Accepted transactions feed the predictor.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      expected_results.push_back(track(pending_cmds.pop_front()));
    end
  end

  // Monitor.
  always @(posedge clk) begin
    lat_pkg::result_t w;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", 64'(result.status), 0);
      end else begin
        w = expected_results.pop_front();
        if (result.status !== w.status)
          report_mismatch("status", 64'(result.status), 64'(w.status));
        if (result.bytes_in_use !== w.bytes_in_use)
          report_mismatch("bytes_in_use", result.bytes_in_use, w.bytes_in_use);
        if (result.blocks_in_use !== w.blocks_in_use)
          report_mismatch("blocks_in_use", 64'(result.blocks_in_use),
                          64'(w.blocks_in_use));
        if (result.bytes_in_use_max !== w.bytes_in_use_max)
          report_mismatch("bytes_in_use_max", result.bytes_in_use_max,
                          w.bytes_in_use_max);
        if (result.total_allocations !== w.total_allocations)
          report_mismatch("total_allocations", result.total_allocations,
                          w.total_allocations);
        if (result.untracked_frees !== w.untracked_frees)
          report_mismatch("untracked_frees", result.untracked_frees, w.untracked_frees);
        if (result.site_bytes_in_use !== w.site_bytes_in_use)
          report_mismatch("site_bytes_in_use", result.site_bytes_in_use,
                          w.site_bytes_in_use);
        if (result.site_peak_bytes !== w.site_peak_bytes)
          report_mismatch("site_peak_bytes", result.site_peak_bytes, w.site_peak_bytes);
        if (result.window_count !== w.window_count)
          report_mismatch("window_count", result.window_count, w.window_count);
        if (result.window_bytes !== w.window_bytes)
          report_mismatch("window_bytes", result.window_bytes, w.window_bytes);
        if (result.peak_frame_count !== w.peak_frame_count)
          report_mismatch("peak_frame_count", result.peak_frame_count, w.peak_frame_count);
        if (result.peak_frame_number !== w.peak_frame_number)
          report_mismatch("peak_frame_number", result.peak_frame_number,
                          w.peak_frame_number);
      end
    end
  end

  function automatic lat_pkg::cmd_t make_cmd(logic [1:0] m, logic [63:0] a,
                                             logic [31:0] sz, logic [11:0] st);
    lat_pkg::cmd_t c;
    c.mode = m;
    c.address = a;
    c.size_bytes = sz;
    c.site = st;
    return c;
  endfunction

  function automatic logic [63:0] rand_addr();
    logic [63:0] a;
    a = {$urandom(), $urandom()};
    if (a < 2) a = 64'h2;
    return a;
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 255);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_cmd(lat_pkg::cmd_t c);
    pending_cmds.push_back(c);
    if (c.mode == lat_pkg::MODE_ALLOC && c.address > 1) live_addrs.push_back(c.address);
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start && expected_results.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_sites(bit v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    use_sites = v;
  endtask

  task automatic random_phase(int n, int fill_bias);
    logic [63:0] a;
    int k;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, 99);
      if (k < fill_bias) begin
        push_cmd(make_cmd(lat_pkg::MODE_ALLOC, rand_addr(), rand_size(), 12'($urandom())));
      end else if (k < 70 && live_addrs.size() > 0) begin
        a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        push_cmd(make_cmd($urandom_range(0, 2) == 0 ? lat_pkg::MODE_ALLOC
                                                    : lat_pkg::MODE_FREE, a,
                          rand_size(), 12'($urandom())));
      end else if (k < 80) begin
        push_cmd(make_cmd(lat_pkg::MODE_FREE, rand_addr(), $urandom(), 12'($urandom())));
      end else if (k < 90) begin
        push_cmd(make_cmd(lat_pkg::MODE_FRAME, {$urandom(), $urandom()}, $urandom(),
                          12'($urandom())));
      end else if (k < 93) begin
        push_cmd(make_cmd(lat_pkg::MODE_STARTUP, {$urandom(), $urandom()}, $urandom(),
                          12'($urandom())));
      end else begin
        push_cmd(make_cmd($urandom_range(0, 1) == 0 ? lat_pkg::MODE_ALLOC
                                                    : lat_pkg::MODE_FREE,
                          64'($urandom_range(0, 1)), $urandom(), 12'($urandom())));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i] = '0;
      tbl_size[i] = '0;
      tbl_site[i] = '0;
    end
    for (int i = 0; i < SITES; i++) begin
      site_live[i] = '0;
      site_peak[i] = '0;
    end
    occupied = 0; live_n = 0;
    live_b = '0; peak_b = '0; allocs = '0; untracked = '0;
    frame_cnt = '0; frame_b = '0; frame_no = '0; worst_cnt = '0; worst_no = '0;
    boot_window_shut = 0; use_sites = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_cmd(make_cmd(lat_pkg::MODE_ALLOC, 64'd0, 32'd5, 12'd1));
    push_cmd(make_cmd(lat_pkg::MODE_FREE, 64'd1, 32'd5, 12'd1));
    push_cmd(make_cmd(lat_pkg::MODE_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
    push_cmd(make_cmd(lat_pkg::MODE_ALLOC, 64'd2, 32'd0, 12'd0));
    push_cmd(make_cmd(lat_pkg::MODE_ALLOC, 64'd2, 32'd100, 12'd7));
    push_cmd(make_cmd(lat_pkg::MODE_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 12'd3));
    push_cmd(make_cmd(lat_pkg::MODE_FREE, 64'hDEAD_BEEF, 32'd0, 12'd0));
    push_cmd(make_cmd(lat_pkg::MODE_FREE, 64'd2, 32'd0, 12'd0));
    push_cmd(make_cmd(lat_pkg::MODE_ALLOC, 64'd2, 32'd9, 12'd0));
    push_cmd(make_cmd(lat_pkg::MODE_STARTUP, 64'd0, 32'd0, 12'd0));
    push_cmd(make_cmd(lat_pkg::MODE_STARTUP, 64'd0, 32'd0, 12'd0));
    push_cmd(make_cmd(lat_pkg::MODE_FRAME, 64'd0, 32'd0, 12'd0));
    push_cmd(make_cmd(lat_pkg::MODE_FRAME, 64'd0, 32'd0, 12'd0));
    drain();

    write_sites(1'b1);
    push_cmd(make_cmd(lat_pkg::MODE_ALLOC, 64'h1234, 32'd50, 12'hFFF));
    push_cmd(make_cmd(lat_pkg::MODE_ALLOC, 64'h1234, 32'd70, 12'd0));
    push_cmd(make_cmd(lat_pkg::MODE_FREE, 64'h1234, 32'd0, 12'hABC));
    random_phase(500, 40);
    drain();

    write_sites(1'b0);
    random_phase(300, 40);
    drain();

    // A mostly allocating phase grows the table and its probe chains.
    write_sites(1'b1);
    random_phase(834, 92);
    drain();

    write_sites(1'b0);
    random_phase(300, 30);
    wait (pending_cmds.size() == 0 && !start && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end
endmodule
